/* rtl/bitmap_block_allocator_macros.svh */
// Assertion macros for the bitmap block allocator.
// Used by bitmap_block_allocator.sv; expects aclk and aresetn in scope.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, off during reset.
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bba_pkg.sv */
// Shared types and constants for the bitmap block allocator.
// No dependencies; used by every bba_* module and the top level.
package bba_pkg;

    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 6;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap naturally
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(ADDR_W + 1);

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   block_address;
        logic [COUNT_W-1:0]  used_count;
    } out_item_t;

    // classified request, front to back
    typedef struct packed {
        logic              kind;
        logic              below_base;
        logic [ADDR_W-1:0] offset;
    } q_entry_t;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [ADDR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ADDR_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SIZE,
        B_DISPATCH,
        B_SCAN,
        B_MUL,
        B_ADDR,
        B_FDIV,
        B_FCHK,
        B_DONE
    } back_state_t;

endpackage

/* rtl/bba_queue.sv */
// Short FIFO of classified requests between front and back.
// Depends on bba_pkg.
module bba_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  bba_pkg::q_entry_t push_entry,
    output logic              pop_valid,
    input  logic              pop,
    output bba_pkg::q_entry_t pop_entry
);

    bba_pkg::q_entry_t                  entry_reg [bba_pkg::QUEUE_DEPTH];
    logic [bba_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [bba_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [bba_pkg::QCNT_W-1:0]         cnt_reg, cnt_next;
    logic                               do_push, do_pop;

    assign push_ready = (cnt_reg != bba_pkg::QCNT_W'(bba_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/bba_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on bba_pkg; shared by the block-size and free-index divisions.
module bba_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  bba_pkg::div_req_t req,
    output bba_pkg::div_rsp_t rsp
);

    localparam int W = bba_pkg::ADDR_W;

    logic [W-1:0]                    dvd_reg, dvd_next;
    logic [W-1:0]                    dsr_reg, dsr_next;
    logic [W-1:0]                    rem_reg, rem_next;
    logic [bba_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [W:0]                      rem_sh;
    logic [W:0]                      diff;
    logic                            fits;

    assign rem_sh = {rem_reg, dvd_reg[W-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};
    assign fits   = (rem_sh >= {1'b0, dsr_reg});

    always_comb begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = bba_pkg::DIV_CNT_W'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[W-1:0] : rem_sh[W-1:0];
            dvd_next = {dvd_reg[W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == bba_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

/* rtl/bba_front.sv */
// Front end: accepts requests and classifies them against the base address.
// Depends on bba_pkg; feeds bba_queue.
module bba_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bba_pkg::in_item_t             s_payload,
    input  logic [bba_pkg::ADDR_W-1:0]    base_address,
    output logic                          push_valid,
    input  logic                          push_ready,
    output bba_pkg::q_entry_t             push_entry
);

    logic              stg_valid_reg, stg_valid_next;
    bba_pkg::q_entry_t stg_reg, stg_next;
    logic              take;

    assign s_ready = !stg_valid_reg || push_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        stg_valid_next = stg_valid_reg;
        stg_next       = stg_reg;
        if (take) begin
            stg_valid_next      = 1'b1;
            stg_next.kind       = s_payload.kind;
            stg_next.below_base = (s_payload.address < base_address);
            stg_next.offset     = s_payload.address - base_address;
        end else if (push_ready) begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stg_reg <= stg_next;
    end

    assign push_valid = stg_valid_reg;
    assign push_entry = stg_reg;

endmodule

/* rtl/bba_back.sv */
// Back end: owns the used map, runs alloc scans and free checks, holds the result.
// Depends on bba_pkg; drives bba_div, pops bba_queue.
module bba_back #(
    parameter int MAX_BLOCKS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  bba_pkg::q_entry_t             q_entry,
    input  logic [bba_pkg::ADDR_W-1:0]    base_address,
    input  logic [bba_pkg::ADDR_W-1:0]    buffer_size,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0] n,
    input  logic                          cfg_change,
    output bba_pkg::div_req_t             div_req,
    input  bba_pkg::div_rsp_t             div_rsp,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bba_pkg::out_item_t            m_payload
);

    localparam int AW = bba_pkg::ADDR_W;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int OW = bba_pkg::COUNT_W;

    bba_pkg::back_state_t            state_reg, state_next;
    bba_pkg::q_entry_t               cur_reg, cur_next;
    logic [AW-1:0]                   size_reg, size_next;
    logic                            size_ok_reg, size_ok_next;
    logic [MAX_BLOCKS-1:0]           map_reg, map_next;
    logic [CW-1:0]                   total_reg, total_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [AW-1:0]                   prod_reg, prod_next;
    logic [AW-1:0]                   quo_reg, quo_next;
    logic [bba_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [AW-1:0]                   res_addr_reg, res_addr_next;
    logic                            out_valid_reg, out_valid_next;
    bba_pkg::out_item_t              out_reg, out_next;
    logic [AW+CW-1:0]                prod_full;

    assign prod_full = size_reg * cnt_reg;

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        size_next       = size_reg;
        size_ok_next    = size_ok_reg;
        map_next        = map_reg;
        total_next      = total_reg;
        cnt_next        = cnt_reg;
        prod_next       = prod_reg;
        quo_next        = quo_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        q_pop           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = buffer_size;
        div_req.divisor  = AW'(n);

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bba_pkg::B_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cur_next = q_entry;
                    if (size_ok_reg) begin
                        state_next = bba_pkg::B_DISPATCH;
                    end else if (n == '0) begin
                        size_next    = '0;
                        size_ok_next = 1'b1;
                        state_next   = bba_pkg::B_DISPATCH;
                    end else begin
                        div_req.start = 1'b1;
                        state_next    = bba_pkg::B_SIZE;
                    end
                end
            end
            bba_pkg::B_SIZE: begin
                if (div_rsp.done) begin
                    size_next    = div_rsp.quotient;
                    size_ok_next = 1'b1;
                    state_next   = bba_pkg::B_DISPATCH;
                end
            end
            bba_pkg::B_DISPATCH: begin
                res_addr_next = '0;
                if (cur_reg.kind == bba_pkg::KIND_ALLOC) begin
                    if (total_reg >= n) begin
                        res_status_next = bba_pkg::STATUS_FULL;
                        state_next      = bba_pkg::B_DONE;
                    end else begin
                        cnt_next   = '0;
                        state_next = bba_pkg::B_SCAN;
                    end
                end else if (cur_reg.below_base || size_reg == '0) begin
                    res_status_next = bba_pkg::STATUS_BAD;
                    state_next      = bba_pkg::B_DONE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = cur_reg.offset;
                    div_req.divisor  = size_reg;
                    state_next       = bba_pkg::B_FDIV;
                end
            end
            bba_pkg::B_SCAN: begin
                if (cnt_reg >= n) begin
                    res_status_next = bba_pkg::STATUS_FULL;
                    state_next      = bba_pkg::B_DONE;
                end else if (!map_reg[cnt_reg[IW-1:0]]) begin
                    map_next[cnt_reg[IW-1:0]] = 1'b1;
                    total_next = total_reg + 1'b1;
                    state_next = bba_pkg::B_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bba_pkg::B_MUL: begin
                prod_next  = prod_full[AW-1:0];
                state_next = bba_pkg::B_ADDR;
            end
            bba_pkg::B_ADDR: begin
                res_addr_next   = base_address + prod_reg;
                res_status_next = bba_pkg::STATUS_OK;
                state_next      = bba_pkg::B_DONE;
            end
            bba_pkg::B_FDIV: begin
                if (div_rsp.done) begin
                    quo_next   = div_rsp.quotient;
                    state_next = bba_pkg::B_FCHK;
                end
            end
            bba_pkg::B_FCHK: begin
                if (quo_reg >= AW'(n) || !map_reg[quo_reg[IW-1:0]]) begin
                    res_status_next = bba_pkg::STATUS_BAD;
                end else begin
                    map_next[quo_reg[IW-1:0]] = 1'b0;
                    if (total_reg != '0) begin
                        total_next = total_reg - 1'b1;
                    end
                    res_status_next = bba_pkg::STATUS_OK;
                end
                state_next = bba_pkg::B_DONE;
            end
            bba_pkg::B_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next         = 1'b1;
                    out_next.status        = res_status_reg;
                    out_next.block_address = res_addr_reg;
                    out_next.used_count    = OW'(total_reg);
                    state_next             = bba_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = bba_pkg::B_IDLE;
            end
        endcase

        // any register write invalidates the cached block size
        if (cfg_change) begin
            size_ok_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bba_pkg::B_IDLE;
            size_ok_reg   <= 1'b0;
            map_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            size_ok_reg   <= size_ok_next;
            map_reg       <= map_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        size_reg       <= size_next;
        cnt_reg        <= cnt_next;
        prod_reg       <= prod_next;
        quo_reg        <= quo_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_reg        <= out_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

/* rtl/bitmap_block_allocator.sv */
// Accept to result valid: alloc scans the used map upward for the lowest free block, then
//   multiplies by the block size and adds the base; free divides the offset by the block
//   size in the 32-step serial divider, then checks. Full pool, below-base or zero-size
//   free: no scan or divide. The first item after any register write with a nonzero count
//   first divides buffer_size by the count. The back end takes one item at a time.
// Reset: synchronous, active-low aresetn clears registers, used map and used total.
`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bba_pkg::in_item_t                 s_payload,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output bba_pkg::out_item_t                m_payload,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bba_pkg::ADDR_W-1:0]        cfg_wdata
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);

    // Configuration registers
    logic [bba_pkg::ADDR_W-1:0]  base_address_reg;
    logic [bba_pkg::ADDR_W-1:0]  buffer_size_reg;
    logic [bba_pkg::COUNT_W-1:0] block_count_reg;
    logic [CW-1:0]               eff_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_address_reg <= '0;
            buffer_size_reg  <= '0;
            block_count_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bba_pkg::REG_BASE_ADDRESS: base_address_reg <= cfg_wdata;
                bba_pkg::REG_BUFFER_SIZE:  buffer_size_reg  <= cfg_wdata;
                bba_pkg::REG_BLOCK_COUNT:
                    block_count_reg <= cfg_wdata[bba_pkg::COUNT_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // Block count saturates at the pool's capacity.
    assign eff_count = (int'(block_count_reg) > MAX_BLOCKS) ? CW'(MAX_BLOCKS)
                                                            : CW'(block_count_reg);

    // Front: takes items, computes offset from base and the below-base flag.
    logic              push_valid;
    logic              push_ready;
    bba_pkg::q_entry_t push_entry;

    bba_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_payload    (s_payload),
        .base_address (base_address_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    // Queue decouples front acceptance from back-end execution.
    logic              q_valid;
    logic              q_pop;
    bba_pkg::q_entry_t q_entry;

    bba_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_entry)
    );

    // Shared serial divider: block size, then offset / block size on frees.
    bba_pkg::div_req_t div_req;
    bba_pkg::div_rsp_t div_rsp;

    bba_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Back: used map, alloc scan, free check, output register.
    bba_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_entry      (q_entry),
        .base_address (base_address_reg),
        .buffer_size  (buffer_size_reg),
        .n            (eff_count),
        .cfg_change   (cfg_we),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_payload    (m_payload)
    );

    // A new division never starts on top of one in flight.
    `BBA_ASSERT_IMP(a_div_no_overlap, div_req.start, !div_rsp.busy, "divider restarted while busy")

    // Once started, the divider reports busy on the following cycle.
    `BBA_ASSERT_NXT(a_div_runs, div_req.start, div_rsp.busy, "divider did not start")

    // Failed requests never carry an address.
    `BBA_ASSERT_IMP(a_fail_no_addr,
        m_valid && m_payload.status != bba_pkg::STATUS_OK && m_payload.block_address != '0,
        1'b0, "failed request returned an address")

    // The back end only pops when the queue holds an item.
    `BBA_ASSERT_IMP(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")

endmodule
